[src/dtcs_pkg.sv]
// Shared types, codes and constants for the disk transfer CHS sequencer.
// Used by the divider, datapath, controller and top level; no dependencies.
package dtcs_pkg;

	// Parameter defaults
	localparam int CHUNK_BYTES_DEF = 32768;
	localparam int BLOCK_SHIFT_DEF = 10;

	// Width of the absolute sector number (32-bit block shifted by up to 7)
	localparam int LSEC_W = 39;
	localparam int DSR_W  = 16;

	// Request codes on the input channel
	localparam logic [2:0] CMD_READ     = 3'd0;
	localparam logic [2:0] CMD_WRITE    = 3'd1;
	localparam logic [2:0] CMD_FORMAT   = 3'd2;
	localparam logic [2:0] CMD_DONE_OK  = 3'd3;
	localparam logic [2:0] CMD_DONE_ERR = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_ISSUE  = 2'd0;
	localparam logic [1:0] KIND_FINISH = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// Controller opcodes
	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_FORMAT = 2'd2;
	localparam logic [1:0] OP_VERIFY = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_HEADS    = 3'd0;
	localparam logic [2:0] REG_SPT      = 3'd1;
	localparam logic [2:0] REG_SEC_SH   = 3'd2;
	localparam logic [2:0] REG_BLK_SH   = 3'd3;
	localparam logic [2:0] REG_PART_SZ  = 3'd4;
	localparam logic [2:0] REG_PART_OFF = 3'd5;

	// Configuration reset values
	localparam logic [7:0]  RST_HEADS    = 8'd7;
	localparam logic [7:0]  RST_SPT      = 8'd18;
	localparam logic [3:0]  RST_SEC_SH   = 4'd10;
	localparam logic [2:0]  RST_BLK_SH   = 3'd0;
	localparam logic [31:0] RST_PART_SZ  = 32'd75737088;
	localparam logic [31:0] RST_PART_OFF = 32'd0;

	// Datapath operations issued by the controller
	localparam logic [3:0] DP_NONE        = 4'd0;
	localparam logic [3:0] DP_REJECT      = 4'd1;
	localparam logic [3:0] DP_FIN_PASTEND = 4'd2;
	localparam logic [3:0] DP_FIN_ZERO    = 4'd3;
	localparam logic [3:0] DP_FIN_ERR     = 4'd4;
	localparam logic [3:0] DP_FIN_OK      = 4'd5;
	localparam logic [3:0] DP_START_FMT   = 4'd6;
	localparam logic [3:0] DP_VERIFY      = 4'd7;
	localparam logic [3:0] DP_START_XFER  = 4'd8;
	localparam logic [3:0] DP_CHUNK_DONE  = 4'd9;
	localparam logic [3:0] DP_PREP        = 4'd10;
	localparam logic [3:0] DP_DIVB        = 4'd11;
	localparam logic [3:0] DP_ISSUE_FMT   = 4'd12;
	localparam logic [3:0] DP_ISSUE_CHUNK = 4'd13;
	localparam logic [3:0] DP_LOAD_OUT    = 4'd14;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [21:0] block_number;
		logic [31:0] byte_count;
		logic [15:0] track_number;
		logic [7:0]  error_code;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  opcode;
		logic [15:0] cylinder;
		logic [7:0]  head;
		logic [15:0] sector;
		logic [15:0] sector_count;
		logic [31:0] buffer_offset;
		logic        failed;
		logic [7:0]  fail_code;
		logic [31:0] residual_bytes;
	} out_t;

	typedef struct packed {
		logic [3:0] op;
	} dp_cmd_t;

	typedef struct packed {
		logic active;
		logic format_mode;
		logic verify_phase;
		logic past_end;
		logic clip_zero;
		logic done_ge_rem;
		logic div_done;
	} dp_stat_t;

endpackage

[src/disk_transfer_chs_sequencer.sv]
// Disk transfer sequencer: block requests to cylinder/head/sector commands.
// Depends on dtcs_pkg, dtcs_ctrl, dtcs_datapath and dtcs_div.
//
// Usage:
//  - Input channel (in_valid/in_ready/in_data) takes read, write and format
//    requests and controller completions (done ok, done error).
//  - Output channel (out_valid/out_ready/out_data) gives one result per
//    request that has one: an issued command, a finish or a rejection.
//  - cfg_we/cfg_addr/cfg_wdata write the geometry and partition registers;
//    write them only while no request is in progress.
// Timing: one request at a time; in_ready is high only when the sequencer
//  is idle. An issued read/write chunk takes two passes of the
//  one-bit-per-cycle divider (cylinder, then head and sector); a format
//  or verify command one divider pass; a finish or rejection needs no
//  divider pass; an ignored completion gives no result.
// Reset: arst_n clears the state machine, the transfer flags and the output
//  valid, and loads the register reset geometry.
// Stall: a result sits in the output register until taken; the next request
//  is accepted meanwhile and its result waits for the register to free up.
module disk_transfer_chs_sequencer #(
	parameter int CHUNK_BYTES = dtcs_pkg::CHUNK_BYTES_DEF,
	parameter int BLOCK_SHIFT = dtcs_pkg::BLOCK_SHIFT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dtcs_pkg::in_t   in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output dtcs_pkg::out_t  out_data,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_addr,
	input  logic [31:0]     cfg_wdata
);
	dtcs_pkg::dp_cmd_t  dp_cmd;
	dtcs_pkg::dp_stat_t dp_stat;

	dtcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_cmd    (in_data.cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_stat   (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	dtcs_datapath #(
		.CHUNK_BYTES (CHUNK_BYTES),
		.BLOCK_SHIFT (BLOCK_SHIFT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat),
		.out_data  (out_data)
	);

endmodule

[src/dtcs_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on dtcs_pkg for operand widths.
module dtcs_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dtcs_pkg::LSEC_W-1:0]  dividend,
	input  logic [dtcs_pkg::DSR_W-1:0]   divisor,
	output logic                         done,
	output logic [dtcs_pkg::LSEC_W-1:0]  quotient,
	output logic [dtcs_pkg::DSR_W-1:0]   remainder
);
	localparam int QW = dtcs_pkg::LSEC_W;
	localparam int RW = dtcs_pkg::DSR_W;
	localparam int CNW = $clog2(QW + 1);

	logic [QW-1:0]  dvd_q;
	logic [RW-1:0]  rem_q;
	logic [RW-1:0]  dsr_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [RW:0]    trial;
	logic           ge;
	logic [RW:0]    diff;

	// One trial subtraction per cycle
	assign trial = {rem_q, dvd_q[QW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	// Shift quotient bits in, hold when idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[QW-2:0], ge};
			rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

[src/dtcs_datapath.sv]
// Datapath: configuration, transfer state, address conversion and result registers.
// Depends on dtcs_pkg and dtcs_div.
module dtcs_datapath #(
	parameter int CHUNK_BYTES = dtcs_pkg::CHUNK_BYTES_DEF,
	parameter int BLOCK_SHIFT = dtcs_pkg::BLOCK_SHIFT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_addr,
	input  logic [31:0]         cfg_wdata,
	input  dtcs_pkg::in_t       in_data,
	input  dtcs_pkg::dp_cmd_t   dp_cmd,
	output dtcs_pkg::dp_stat_t  dp_stat,
	output dtcs_pkg::out_t      out_data
);
	localparam int SW   = 22 + BLOCK_SHIFT;
	localparam int CW   = (SW > 32) ? SW : 32;
	localparam int CBW  = $clog2(CHUNK_BYTES + 1);
	localparam int SUMW = CBW + 16;
	localparam int LW   = dtcs_pkg::LSEC_W;

	// Configuration registers
	logic [7:0]  heads_q, spt_q;
	logic [3:0]  sec_sh_q;
	logic [2:0]  blk_sh_q;
	logic [31:0] part_sz_q, part_off_q;

	// Transfer state
	logic        active_q, fmt_q, ver_q, wr_q;
	logic [15:0] trk_q;
	logic [31:0] blk_q;
	logic [32:0] rem_q;
	logic [15:0] csec_q;
	logic [31:0] coff_q;
	logic [15:0] cyl_q;
	dtcs_pkg::out_t res_q;
	dtcs_pkg::out_t res_n;
	logic           res_ld;
	dtcs_pkg::out_t out_q;

	// Combinational terms
	logic [7:0]    eff_h, eff_spt;
	logic [15:0]   spc;
	logic [CW-1:0] start_c, size_c;
	logic [31:0]   avail, clipped;
	logic          past_end;
	logic [32:0]   done_b;
	logic [CBW-1:0] nbytes;
	logic [SUMW-1:0] round_sum;
	logic [15:0]   csec_n;
	logic [LW-1:0] lsec;

	logic          div_start;
	logic [LW-1:0] div_dvd;
	logic [15:0]   div_dsr;
	logic          div_done;
	logic [LW-1:0] div_quo;
	logic [15:0]   div_rem;

	// Geometry with zero taken as one
	assign eff_h   = (heads_q == 8'd0) ? 8'd1 : heads_q;
	assign eff_spt = (spt_q == 8'd0) ? 8'd1 : spt_q;
	assign spc     = 16'(eff_h * eff_spt);

	// Partition clipping of a new request
	assign start_c  = CW'(in_data.block_number) << BLOCK_SHIFT;
	assign size_c   = CW'(part_sz_q);
	assign past_end = start_c >= size_c;
	assign avail    = 32'(size_c - start_c);
	assign clipped  = (in_data.byte_count > avail) ? avail : in_data.byte_count;

	// Bytes finished by the chunk in flight
	assign done_b = 33'(csec_q) << sec_sh_q;

	// Sector count of the next chunk, rounded up
	assign nbytes    = (rem_q < 33'(CHUNK_BYTES)) ? rem_q[CBW-1:0] : CBW'(CHUNK_BYTES);
	assign round_sum = SUMW'(nbytes) + ((SUMW'(1) << sec_sh_q) - SUMW'(1));
	assign csec_n    = 16'(round_sum >> sec_sh_q);

	assign lsec = LW'(blk_q) << blk_sh_q;

	// Divider operands: first pass cylinder (and head for a format), second pass head and sector
	always_comb begin
		div_start = 1'b0;
		div_dvd   = lsec;
		div_dsr   = spc;
		case (dp_cmd.op)
			dtcs_pkg::DP_PREP: begin
				div_start = 1'b1;
				if (fmt_q) begin
					div_dvd = LW'(trk_q);
					div_dsr = 16'(eff_h);
				end
			end
			dtcs_pkg::DP_DIVB: begin
				div_start = 1'b1;
				div_dvd   = LW'(div_rem);
				div_dsr   = 16'(eff_spt);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	dtcs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dvd),
		.divisor   (div_dsr),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heads_q    <= dtcs_pkg::RST_HEADS;
			spt_q      <= dtcs_pkg::RST_SPT;
			sec_sh_q   <= dtcs_pkg::RST_SEC_SH;
			blk_sh_q   <= dtcs_pkg::RST_BLK_SH;
			part_sz_q  <= dtcs_pkg::RST_PART_SZ;
			part_off_q <= dtcs_pkg::RST_PART_OFF;
		end else if (cfg_we) begin
			case (cfg_addr)
				dtcs_pkg::REG_HEADS:    heads_q    <= cfg_wdata[7:0];
				dtcs_pkg::REG_SPT:      spt_q      <= cfg_wdata[7:0];
				dtcs_pkg::REG_SEC_SH:   sec_sh_q   <= cfg_wdata[3:0];
				dtcs_pkg::REG_BLK_SH:   blk_sh_q   <= cfg_wdata[2:0];
				dtcs_pkg::REG_PART_SZ:  part_sz_q  <= cfg_wdata;
				dtcs_pkg::REG_PART_OFF: part_off_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Mode flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			fmt_q    <= 1'b0;
			ver_q    <= 1'b0;
			wr_q     <= 1'b0;
		end else begin
			case (dp_cmd.op)
				dtcs_pkg::DP_START_FMT: begin
					active_q <= 1'b1;
					fmt_q    <= 1'b1;
					ver_q    <= 1'b0;
				end
				dtcs_pkg::DP_VERIFY: begin
					ver_q <= 1'b1;
				end
				dtcs_pkg::DP_START_XFER: begin
					active_q <= 1'b1;
					fmt_q    <= 1'b0;
					ver_q    <= 1'b0;
					wr_q     <= (in_data.cmd == dtcs_pkg::CMD_WRITE);
				end
				dtcs_pkg::DP_FIN_PASTEND, dtcs_pkg::DP_FIN_ZERO,
				dtcs_pkg::DP_FIN_ERR, dtcs_pkg::DP_FIN_OK: begin
					active_q <= 1'b0;
					fmt_q    <= 1'b0;
					ver_q    <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Build the result for the operation at hand
	always_comb begin
		res_ld = 1'b1;
		res_n  = '0;
		case (dp_cmd.op)
			dtcs_pkg::DP_REJECT: begin
				res_n.kind = dtcs_pkg::KIND_REJECT;
			end
			dtcs_pkg::DP_FIN_PASTEND: begin
				res_n.kind           = dtcs_pkg::KIND_FINISH;
				res_n.residual_bytes = in_data.byte_count;
			end
			dtcs_pkg::DP_FIN_ZERO, dtcs_pkg::DP_FIN_OK: begin
				res_n.kind = dtcs_pkg::KIND_FINISH;
			end
			dtcs_pkg::DP_FIN_ERR: begin
				res_n.kind           = dtcs_pkg::KIND_FINISH;
				res_n.failed         = 1'b1;
				res_n.fail_code      = in_data.error_code;
				res_n.residual_bytes = fmt_q ? 32'd0 : rem_q[31:0];
			end
			dtcs_pkg::DP_ISSUE_FMT: begin
				res_n.kind         = dtcs_pkg::KIND_ISSUE;
				res_n.opcode       = ver_q ? dtcs_pkg::OP_VERIFY : dtcs_pkg::OP_FORMAT;
				res_n.cylinder     = div_quo[15:0];
				res_n.head         = div_rem[7:0];
				res_n.sector_count = 16'(heads_q);
			end
			dtcs_pkg::DP_ISSUE_CHUNK: begin
				res_n.kind          = dtcs_pkg::KIND_ISSUE;
				res_n.opcode        = wr_q ? dtcs_pkg::OP_WRITE : dtcs_pkg::OP_READ;
				res_n.cylinder      = cyl_q;
				res_n.head          = div_quo[7:0];
				res_n.sector        = div_rem;
				res_n.sector_count  = csec_q;
				res_n.buffer_offset = coff_q;
			end
			default: begin
				res_ld = 1'b0;
			end
		endcase
	end

	// Stage the result until the output register is free
	always_ff @(posedge clk) begin
		if (res_ld) begin
			res_q <= res_n;
		end
	end

	// Transfer state and output register
	always_ff @(posedge clk) begin
		case (dp_cmd.op)
			dtcs_pkg::DP_START_FMT: begin
				trk_q <= in_data.track_number;
			end
			dtcs_pkg::DP_START_XFER: begin
				blk_q  <= 32'(in_data.block_number) + (part_off_q >> BLOCK_SHIFT);
				rem_q  <= {1'b0, clipped};
				coff_q <= '0;
			end
			dtcs_pkg::DP_CHUNK_DONE: begin
				coff_q <= coff_q + done_b[31:0];
				blk_q  <= blk_q + 32'(csec_q >> blk_sh_q);
				rem_q  <= rem_q - done_b;
			end
			dtcs_pkg::DP_PREP: begin
				if (!fmt_q) begin
					csec_q <= csec_n;
				end
			end
			dtcs_pkg::DP_DIVB: begin
				cyl_q <= div_quo[15:0];
			end
			dtcs_pkg::DP_LOAD_OUT: begin
				out_q <= res_q;
			end
			default: ;
		endcase
	end

	assign dp_stat.active       = active_q;
	assign dp_stat.format_mode  = fmt_q;
	assign dp_stat.verify_phase = ver_q;
	assign dp_stat.past_end     = past_end;
	assign dp_stat.clip_zero    = (clipped == 32'd0);
	assign dp_stat.done_ge_rem  = done_b >= rem_q;
	assign dp_stat.div_done     = div_done;

	assign out_data = out_q;

endmodule

[src/dtcs_ctrl.sv]
// Controller state machine: request decode, divider sequencing, output register valid.
// Depends on dtcs_pkg; drives dtcs_datapath through dp_cmd.
module dtcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [2:0]          in_cmd,
	output logic                out_valid,
	input  logic                out_ready,
	input  dtcs_pkg::dp_stat_t  dp_stat,
	output dtcs_pkg::dp_cmd_t   dp_cmd
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_DIVA = 3'd2;
	localparam logic [2:0] ST_DIVB = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0] state_q, state_n;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;
	logic [3:0] op;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Decode requests and step through the conversion
	always_comb begin
		state_n = state_q;
		op      = dtcs_pkg::DP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_cmd == dtcs_pkg::CMD_READ || in_cmd == dtcs_pkg::CMD_WRITE ||
					    in_cmd == dtcs_pkg::CMD_FORMAT) begin
						if (dp_stat.active) begin
							op      = dtcs_pkg::DP_REJECT;
							state_n = ST_OUT;
						end else if (in_cmd == dtcs_pkg::CMD_FORMAT) begin
							op      = dtcs_pkg::DP_START_FMT;
							state_n = ST_PREP;
						end else if (dp_stat.past_end) begin
							op      = dtcs_pkg::DP_FIN_PASTEND;
							state_n = ST_OUT;
						end else if (dp_stat.clip_zero) begin
							op      = dtcs_pkg::DP_FIN_ZERO;
							state_n = ST_OUT;
						end else begin
							op      = dtcs_pkg::DP_START_XFER;
							state_n = ST_PREP;
						end
					end else if (dp_stat.active && in_cmd == dtcs_pkg::CMD_DONE_ERR) begin
						op      = dtcs_pkg::DP_FIN_ERR;
						state_n = ST_OUT;
					end else if (dp_stat.active && in_cmd == dtcs_pkg::CMD_DONE_OK) begin
						if (dp_stat.format_mode) begin
							if (dp_stat.verify_phase) begin
								op      = dtcs_pkg::DP_FIN_OK;
								state_n = ST_OUT;
							end else begin
								op      = dtcs_pkg::DP_VERIFY;
								state_n = ST_PREP;
							end
						end else if (dp_stat.done_ge_rem) begin
							op      = dtcs_pkg::DP_FIN_OK;
							state_n = ST_OUT;
						end else begin
							op      = dtcs_pkg::DP_CHUNK_DONE;
							state_n = ST_PREP;
						end
					end
				end
			end
			ST_PREP: begin
				op      = dtcs_pkg::DP_PREP;
				state_n = ST_DIVA;
			end
			ST_DIVA: begin
				if (dp_stat.div_done) begin
					if (dp_stat.format_mode) begin
						op      = dtcs_pkg::DP_ISSUE_FMT;
						state_n = ST_OUT;
					end else begin
						op      = dtcs_pkg::DP_DIVB;
						state_n = ST_DIVB;
					end
				end
			end
			ST_DIVB: begin
				if (dp_stat.div_done) begin
					op      = dtcs_pkg::DP_ISSUE_CHUNK;
					state_n = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					op      = dtcs_pkg::DP_LOAD_OUT;
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// Advance state, hold the output valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (op == dtcs_pkg::DP_LOAD_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dp_cmd.op = op;
	assign out_valid = out_valid_q;

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(op == dtcs_pkg::DP_LOAD_OUT) |-> (!out_valid_q || out_ready))
		else $error("result overwritten while stalled");

	// Divider completes only while a conversion is waiting for it
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		dp_stat.div_done |-> (state_q == ST_DIVA || state_q == ST_DIVB))
		else $error("divider done outside conversion");

	// A request arriving while active is answered by a rejection
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && dp_stat.active &&
		 (in_cmd == dtcs_pkg::CMD_READ || in_cmd == dtcs_pkg::CMD_WRITE ||
		  in_cmd == dtcs_pkg::CMD_FORMAT)) |=> (state_q == ST_OUT))
		else $error("busy request not rejected");

	// Second division pass is only used for read/write transfers
	a_divb_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVB) |-> !dp_stat.format_mode)
		else $error("format entered second division");

endmodule
